[design/saws_pkg.sv]
// shared types and constants for the self-avoiding walk step block
`default_nettype none
package saws_pkg;

	localparam int GRID_SIDE_DEF  = 256;
	localparam int LIMIT_W        = 16;
	localparam int VISIT_W        = 17;
	localparam int POS_W          = 8;
	localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 16'd1000;

	localparam logic [1:0] DIR_PX = 2'd0;
	localparam logic [1:0] DIR_PY = 2'd1;
	localparam logic [1:0] DIR_MX = 2'd2;
	localparam logic [1:0] DIR_MY = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TGT_RD,
		ST_TGT_CHK,
		ST_NB_RD,
		ST_NB_LAST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       clear_en;
		logic       accept;
		logic       tgt_issue;
		logic       tgt_eval;
		logic       nb_issue;
		logic [1:0] nb_idx;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic over;
	} sts_t;

endpackage
`default_nettype wire

[design/self_avoiding_walk_step_top.sv]
// top level of the self-avoiding walk step block
// One move attempt is taken per item when start is high and busy low. busy stays
// high while an item runs, so the block does not take a new item before the last
// one is through; the target check is skipped once the walk has ended. The steps
// follow the map memory's single read port: one read of the target cell, one write,
// then four neighbour reads and their collection.
// The result shows on the output ports for one cycle with done high and cannot be
// held off. After reset the visit map, rounded up to a power of two per side, is
// cleared with busy high; step_limit may still be written during that time.
`default_nettype none
module self_avoiding_walk_step_top #(
	parameter int GRID_SIDE = saws_pkg::GRID_SIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    direction,
	input  wire logic                          step_limit_we,
	input  wire logic [saws_pkg::LIMIT_W-1:0]  step_limit,
	output logic                               done,
	output logic                               moved,
	output logic      [saws_pkg::POS_W-1:0]    pos_x,
	output logic      [saws_pkg::POS_W-1:0]    pos_y,
	output logic      [saws_pkg::VISIT_W-1:0]  visit_number,
	output logic                               trapped,
	output logic                               finished
);
	import saws_pkg::*;

	cmd_t cmd;
	sts_t sts;

	saws_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	saws_dp #(
		.GRID_SIDE(GRID_SIDE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.step_limit_we(step_limit_we),
		.step_limit   (step_limit),
		.direction    (direction),
		.done         (done),
		.moved        (moved),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.visit_number (visit_number),
		.trapped      (trapped),
		.finished     (finished)
	);

endmodule
`default_nettype wire

[design/saws_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module saws_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[design/saws_ctrl.sv]
// controller state machine sequencing map reads and writes for one item
`default_nettype none
module saws_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire saws_pkg::sts_t sts,
	output saws_pkg::cmd_t      cmd
);
	import saws_pkg::*;

	state_t     state_q, state_next;
	logic [1:0] nb_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			nb_cnt_q <= 2'd0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_NB_RD) begin
				nb_cnt_q <= nb_cnt_q + 2'd1;
			end else begin
				nb_cnt_q <= 2'd0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_next = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_next = ST_TGT_RD;
			end
			ST_TGT_RD: begin
				state_next = sts.over ? ST_NB_RD : ST_TGT_CHK;
			end
			ST_TGT_CHK: begin
				state_next = ST_NB_RD;
			end
			ST_NB_RD: begin
				if (nb_cnt_q == 2'd3) state_next = ST_NB_LAST;
			end
			ST_NB_LAST: begin
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		busy          = 1'b1;
		cmd.nb_idx    = nb_cnt_q;
		unique case (state_q)
			ST_CLEAR:   cmd.clear_en = 1'b1;
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_TGT_RD:  cmd.tgt_issue = !sts.over;
			ST_TGT_CHK: cmd.tgt_eval = 1'b1;
			ST_NB_RD:   cmd.nb_issue = 1'b1;
			ST_NB_LAST: cmd.finish = 1'b0;
			ST_FINISH:  cmd.finish = 1'b1;
			default:    busy = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

[design/saws_dp.sv]
// datapath: walker state, visit map memory, neighbour checks and result registers
`default_nettype none
module saws_dp #(
	parameter int GRID_SIDE = saws_pkg::GRID_SIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire saws_pkg::cmd_t                cmd,
	output saws_pkg::sts_t                     sts,
	input  wire logic                          step_limit_we,
	input  wire logic [saws_pkg::LIMIT_W-1:0]  step_limit,
	input  wire logic [1:0]                    direction,
	output logic                               done,
	output logic                               moved,
	output logic      [saws_pkg::POS_W-1:0]    pos_x,
	output logic      [saws_pkg::POS_W-1:0]    pos_y,
	output logic      [saws_pkg::VISIT_W-1:0]  visit_number,
	output logic                               trapped,
	output logic                               finished
);
	import saws_pkg::*;

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam logic [CW-1:0] CENTRE = CW'(GRID_SIDE / 2);
	localparam logic [CW-1:0] MAXC   = CW'(GRID_SIDE - 1);

	// neighbour of (x, y) in direction d: {outside, y, x}
	function automatic logic [AW:0] nbr(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [1:0] d);
		logic [CW-1:0] nx;
		logic [CW-1:0] ny;
		logic          o;
		nx = x;
		ny = y;
		o  = 1'b0;
		unique case (d)
			DIR_PX: begin
				o  = (x == MAXC);
				nx = x + CW'(1);
			end
			DIR_PY: begin
				o  = (y == MAXC);
				ny = y + CW'(1);
			end
			DIR_MX: begin
				o  = (x == '0);
				nx = x - CW'(1);
			end
			DIR_MY: begin
				o  = (y == '0);
				ny = y - CW'(1);
			end
			default: o = 1'b1;
		endcase
		return {o, ny, nx};
	endfunction

	logic [CW-1:0]      x_q, y_q;
	logic [VISIT_W-1:0] visit_q;
	logic [LIMIT_W-1:0] loop_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               over_q;
	logic [1:0]         dir_q;
	logic               moved_q;
	logic [AW-1:0]      clr_q;
	logic [3:0]         trap_q;

	logic               tgt_out_s1;
	logic               nb_vld_s1;
	logic [1:0]         nb_idx_s1;
	logic               nb_out_s1;

	logic               done_q, out_moved_q, out_trap_q, out_fin_q;
	logic [POS_W-1:0]   out_x_q, out_y_q;
	logic [VISIT_W-1:0] out_visit_q;

	logic [AW:0]   tgt, nb;
	logic          move;
	logic          at_limit;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [0:0]    ram_wdata, ram_rdata;

	assign tgt      = nbr(x_q, y_q, dir_q);
	assign nb       = nbr(x_q, y_q, cmd.nb_idx);
	assign at_limit = (loop_q >= limit_q);
	assign move     = cmd.tgt_eval && !tgt_out_s1 && !ram_rdata[0];

	assign ram_re    = (cmd.tgt_issue && !tgt[AW]) || (cmd.nb_issue && !nb[AW]);
	assign ram_raddr = cmd.nb_issue ? nb[AW-1:0] : tgt[AW-1:0];
	assign ram_we    = cmd.clear_en || move;
	assign ram_waddr = cmd.clear_en ? clr_q : tgt[AW-1:0];
	assign ram_wdata = cmd.clear_en ? 1'(clr_q == {CENTRE, CENTRE}) : 1'b1;

	saws_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sts.clear_done = &clr_q;
	assign sts.over       = over_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= CENTRE;
			y_q         <= CENTRE;
			visit_q     <= VISIT_W'(1);
			loop_q      <= LIMIT_W'(1);
			limit_q     <= STEP_LIMIT_RST;
			over_q      <= 1'b0;
			clr_q       <= '0;
			nb_vld_s1   <= 1'b0;
			done_q      <= 1'b0;
			out_moved_q <= 1'b0;
			out_trap_q  <= 1'b0;
			out_fin_q   <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_visit_q <= '0;
		end else begin
			if (step_limit_we) limit_q <= step_limit;
			if (cmd.clear_en) clr_q <= clr_q + AW'(1);
			if (cmd.accept) over_q <= over_q || at_limit;
			if (move) begin
				x_q     <= tgt[CW-1:0];
				y_q     <= tgt[AW-1:CW];
				visit_q <= visit_q + VISIT_W'(1);
				loop_q  <= loop_q + LIMIT_W'(1);
			end
			nb_vld_s1 <= cmd.nb_issue;
			done_q    <= cmd.finish;
			if (cmd.finish) begin
				over_q      <= over_q || (&trap_q) || at_limit;
				out_moved_q <= moved_q;
				out_x_q     <= POS_W'(x_q);
				out_y_q     <= POS_W'(y_q);
				out_visit_q <= visit_q;
				out_trap_q  <= &trap_q;
				out_fin_q   <= over_q || (&trap_q) || at_limit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dir_q   <= direction;
			moved_q <= 1'b0;
		end
		if (move) moved_q <= 1'b1;
		if (cmd.tgt_issue) tgt_out_s1 <= tgt[AW];
		if (cmd.nb_issue) begin
			nb_idx_s1 <= cmd.nb_idx;
			nb_out_s1 <= nb[AW];
		end
		if (nb_vld_s1) trap_q[nb_idx_s1] <= nb_out_s1 || ram_rdata[0];
	end

	assign done         = done_q;
	assign moved        = out_moved_q;
	assign pos_x        = out_x_q;
	assign pos_y        = out_y_q;
	assign visit_number = out_visit_q;
	assign trapped      = out_trap_q;
	assign finished     = out_fin_q;

endmodule
`default_nettype wire

[design/saws_chk.sv]
// port-level checker for the self-avoiding walk step block and its bind
`default_nettype none
module saws_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic moved,
	input wire logic trapped,
	input wire logic finished
);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding busy cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted item did not raise busy");

	a_trap_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && trapped |-> finished)
		else $error("trapped walker not reported finished");

	a_no_move_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		done && moved |-> !$past(finished))
		else $error("walker moved after walk ended");

endmodule

bind self_avoiding_walk_step_top saws_chk u_chk (.*);
`default_nettype wire
